[design/cdta_pkg.sv]
// shared types and constants of the calendar date and time adjust block
// request and result payloads, controller commands, datapath status
// no dependencies
package cdta_pkg;

    // calendar constants
    localparam logic [11:0] YEAR_MIN     = 12'd2000;
    localparam logic [11:0] YEAR_MAX     = 12'd2099;
    localparam logic [15:0] DAYS_TO_2000 = 16'd10957;
    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN  = 17'd60;
    localparam logic [16:0] DAYS_PER_QUAD = 17'd1461;
    localparam logic [16:0] DAYS_PER_YEAR = 17'd365;
    localparam logic [16:0] DAYS_PER_WEEK = 17'd7;
    localparam logic [10:0] DAYS_LEAP_YEAR = 11'd366;
    localparam logic [15:0] WEEKDAY_BIAS = 16'd4;
    localparam logic [33:0] EPOCH_LO     = 34'd946684800;
    localparam logic [33:0] EPOCH_HI     = 34'd4102444799;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // shared divider geometry
    localparam int DIV_W   = 32;
    localparam int DSR_W   = 17;

    // reciprocals floor(2^32 / d) of the constant divisors
    localparam logic [31:0] RCP_DAY   = 32'(64'h1_0000_0000 / 64'(SEC_PER_DAY));
    localparam logic [31:0] RCP_HOUR  = 32'(64'h1_0000_0000 / 64'(SEC_PER_HOUR));
    localparam logic [31:0] RCP_MIN   = 32'(64'h1_0000_0000 / 64'(SEC_PER_MIN));
    localparam logic [31:0] RCP_QUAD  = 32'(64'h1_0000_0000 / 64'(DAYS_PER_QUAD));
    localparam logic [31:0] RCP_YEAR  = 32'(64'h1_0000_0000 / 64'(DAYS_PER_YEAR));
    localparam logic [31:0] RCP_WEEK  = 32'(64'h1_0000_0000 / 64'(DAYS_PER_WEEK));

    // request payload
    typedef struct packed {
        logic               func;
        logic [11:0]        set_year;
        logic [7:0]         set_month;
        logic [7:0]         set_day;
        logic [7:0]         set_hour;
        logic [7:0]         set_minute;
        logic [7:0]         set_second;
        logic signed [31:0] offset_seconds;
    } req_t;

    // result payload
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic [31:0] epoch_seconds;
        logic        range_error;
    } rsp_t;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_DAYS_INIT,
        OP_MONTH_SUM,
        OP_MUL_DAY,
        OP_ADD_TOD,
        OP_WDAY_START,
        OP_WDAY_END,
        OP_ADD_OFF,
        OP_DAY_START,
        OP_DAY_END,
        OP_HOUR_START,
        OP_HOUR_END,
        OP_MIN_START,
        OP_MIN_END,
        OP_QUAD_START,
        OP_QUAD_END,
        OP_YEAR_START,
        OP_YEAR_END,
        OP_MONTH_CONV,
        OP_COMMIT,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic func;
        logic month_done;
        logic off_skip;
        logic rest_ge_leap;
        logic conv_done;
        logic div_busy;
        logic out_free;
    } dp_status_t;

    // month length, every year divisible by 4 counted as leap
    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [11:0] y);
        logic [3:0] idx;
        logic [4:0] len;
        if (m == 4'd0)
            idx = 4'd0;
        else if (m > 4'd12)
            idx = 4'd11;
        else
            idx = m - 4'd1;
        len = MONTH_LEN[idx];
        if (idx == 4'd1 && y[1:0] == 2'b00)
            len = 5'd29;
        return len;
    endfunction

endpackage

[design/cdta_stream_if.sv]
// valid/ready stream channel carrying one payload type
// payload type is given at instantiation; no other dependencies
interface cdta_stream_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

[design/cdta_div.sv]
// shared divider for the fixed set of calendar divisors: reciprocal multiply,
// back multiply and one correction step, each in its own phase after start
// depends on cdta_pkg for the operand widths and reciprocals
module cdta_div
    import cdta_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quo,
    output logic [DSR_W-1:0] rem
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MUL,
        PH_REM,
        PH_FIX
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DSR_W:0]   rem_reg, rem_next;

    logic [DIV_W-1:0]       rcp_sel;
    logic [2*DIV_W-1:0]     est_prod;
    logic [DIV_W+DSR_W-1:0] back_prod;
    logic [DIV_W-1:0]       rem_wide;

    // reciprocal of the registered divisor
    always_comb
    begin
        case (dsr_reg)
            SEC_PER_DAY:   rcp_sel = RCP_DAY;
            SEC_PER_HOUR:  rcp_sel = RCP_HOUR;
            SEC_PER_MIN:   rcp_sel = RCP_MIN;
            DAYS_PER_QUAD: rcp_sel = RCP_QUAD;
            DAYS_PER_YEAR: rcp_sel = RCP_YEAR;
            DAYS_PER_WEEK: rcp_sel = RCP_WEEK;
            default:       rcp_sel = '0;
        endcase
    end

    // quotient estimate is low by at most one
    assign est_prod  = {{DIV_W{1'b0}}, dvd_reg} * {{DIV_W{1'b0}}, rcp_sel};
    assign back_prod = {{DSR_W{1'b0}}, quo_reg} * {{DIV_W{1'b0}}, dsr_reg};
    assign rem_wide  = dvd_reg - back_prod[DIV_W-1:0];

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    dvd_next   = dividend;
                    dsr_next   = divisor;
                    phase_next = PH_MUL;
                end
            end
            PH_MUL:
            begin
                quo_next   = est_prod[2*DIV_W-1:DIV_W];
                phase_next = PH_REM;
            end
            PH_REM:
            begin
                rem_next   = rem_wide[DSR_W:0];
                phase_next = PH_FIX;
            end
            PH_FIX:
            begin
                if (rem_reg >= {1'b0, dsr_reg})
                begin
                    quo_next = quo_reg + DIV_W'(1);
                    rem_next = rem_reg - {1'b0, dsr_reg};
                end
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else
            phase_reg <= phase_next;
    end

    // operand and result registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy = phase_reg != PH_IDLE;
    assign quo  = quo_reg;
    assign rem  = rem_reg[DSR_W-1:0];

endmodule

[design/cdta_datapath.sv]
// datapath: stored date and time, day and second counts, conversion back
// depends on cdta_pkg and instantiates the shared divider cdta_div
module cdta_datapath
    import cdta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    input  req_t       req_data,
    input  logic       rsp_ready,
    output logic       rsp_valid,
    output rsp_t       rsp_data
);

    // stored date and time
    logic [11:0] cur_year_reg, cur_year_next;
    logic [3:0]  cur_month_reg, cur_month_next;
    logic [4:0]  cur_day_reg, cur_day_next;
    logic [4:0]  cur_hour_reg, cur_hour_next;
    logic [5:0]  cur_minute_reg, cur_minute_next;
    logic [5:0]  cur_second_reg, cur_second_next;

    // working registers
    req_t        req_reg, req_next;
    logic [15:0] days_reg, days_next;
    logic [3:0]  mcnt_reg, mcnt_next;
    logic [31:0] epoch_reg, epoch_next;
    logic [16:0] rem_reg, rem_next;
    logic [2:0]  wday_reg, wday_next;
    logic        err_reg, err_next;
    logic [11:0] conv_year_reg, conv_year_next;
    logic [3:0]  conv_month_reg, conv_month_next;
    logic [10:0] rest_reg, rest_next;
    logic [4:0]  conv_hour_reg, conv_hour_next;
    logic [5:0]  conv_min_reg, conv_min_next;
    logic [5:0]  conv_sec_reg, conv_sec_next;
    rsp_t        out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    // divider hookup
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DSR_W-1:0] div_divisor;
    logic             div_busy;
    logic [DIV_W-1:0] div_quo;
    logic [DSR_W-1:0] div_rem;

    // helpers
    logic [6:0]  yo;
    logic [7:0]  yo_p3;
    logic [32:0] day_prod;
    logic [16:0] tod;
    logic [33:0] nt;
    logic        off_zero;
    logic        off_bad;
    logic [4:0]  sum_dim;
    logic [4:0]  conv_dim;
    logic        conv_done;
    logic [11:0] ld_year;
    logic [3:0]  ld_month;
    logic [4:0]  ld_dim;
    logic [4:0]  ld_day;

    cdta_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // day count and second count arithmetic
    assign yo       = 7'(cur_year_reg - YEAR_MIN);
    assign yo_p3    = {1'b0, yo} + 8'd3;
    assign day_prod = {17'd0, days_reg} * {16'd0, SEC_PER_DAY};
    assign tod      = 17'(cur_hour_reg) * SEC_PER_HOUR + 17'(cur_minute_reg) * SEC_PER_MIN
                    + 17'(cur_second_reg);

    // new instant and its range check
    assign nt       = {2'b00, epoch_reg} + {{2{req_reg.offset_seconds[31]}},
                                            req_reg.offset_seconds};
    assign off_zero = req_reg.offset_seconds == 32'sd0;
    assign off_bad  = ($signed(nt) < $signed(EPOCH_LO)) || ($signed(nt) > $signed(EPOCH_HI));

    // month walks
    assign sum_dim   = days_in_month(mcnt_reg, cur_year_reg);
    assign conv_dim  = days_in_month(conv_month_reg, conv_year_reg);
    assign conv_done = (conv_month_reg >= 4'd12) || (rest_reg < 11'(conv_dim));

    // clamping of a load request
    always_comb
    begin
        if (req_reg.set_year < YEAR_MIN)
            ld_year = YEAR_MIN;
        else if (req_reg.set_year > YEAR_MAX)
            ld_year = YEAR_MAX;
        else
            ld_year = req_reg.set_year;

        if (req_reg.set_month < 8'd1)
            ld_month = 4'd1;
        else if (req_reg.set_month > 8'd12)
            ld_month = 4'd12;
        else
            ld_month = req_reg.set_month[3:0];

        ld_dim = days_in_month(ld_month, ld_year);

        if (req_reg.set_day < 8'd1)
            ld_day = 5'd1;
        else if (req_reg.set_day > {3'b000, ld_dim})
            ld_day = ld_dim;
        else
            ld_day = req_reg.set_day[4:0];
    end

    // divider operand selection
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = epoch_reg;
        div_divisor  = SEC_PER_DAY;
        case (cmd.op)
            OP_WDAY_START:
            begin
                div_start    = 1'b1;
                div_dividend = {16'd0, days_reg} + {16'd0, WEEKDAY_BIAS};
                div_divisor  = DAYS_PER_WEEK;
            end
            OP_DAY_START:
            begin
                div_start    = 1'b1;
                div_dividend = epoch_reg;
                div_divisor  = SEC_PER_DAY;
            end
            OP_HOUR_START:
            begin
                div_start    = 1'b1;
                div_dividend = {15'd0, rem_reg};
                div_divisor  = SEC_PER_HOUR;
            end
            OP_MIN_START:
            begin
                div_start    = 1'b1;
                div_dividend = {15'd0, rem_reg};
                div_divisor  = SEC_PER_MIN;
            end
            OP_QUAD_START:
            begin
                div_start    = 1'b1;
                div_dividend = {16'd0, days_reg - DAYS_TO_2000};
                div_divisor  = DAYS_PER_QUAD;
            end
            OP_YEAR_START:
            begin
                div_start    = 1'b1;
                div_dividend = {21'd0, rest_reg - DAYS_LEAP_YEAR};
                div_divisor  = DAYS_PER_YEAR;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // operation decode
    always_comb
    begin
        cur_year_next   = cur_year_reg;
        cur_month_next  = cur_month_reg;
        cur_day_next    = cur_day_reg;
        cur_hour_next   = cur_hour_reg;
        cur_minute_next = cur_minute_reg;
        cur_second_next = cur_second_reg;
        req_next        = req_reg;
        days_next       = days_reg;
        mcnt_next       = mcnt_reg;
        epoch_next      = epoch_reg;
        rem_next        = rem_reg;
        wday_next       = wday_reg;
        err_next        = err_reg;
        conv_year_next  = conv_year_reg;
        conv_month_next = conv_month_reg;
        rest_next       = rest_reg;
        conv_hour_next  = conv_hour_reg;
        conv_min_next   = conv_min_reg;
        conv_sec_next   = conv_sec_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        if (rsp_ready)
            out_valid_next = 1'b0;

        case (cmd.op)
            OP_CAPTURE:
            begin
                req_next = req_data;
                err_next = 1'b0;
            end
            OP_LOAD:
            begin
                if (!req_reg.func)
                begin
                    cur_year_next   = ld_year;
                    cur_month_next  = ld_month;
                    cur_day_next    = ld_day;
                    cur_hour_next   = (req_reg.set_hour > 8'd23) ? 5'd23 : req_reg.set_hour[4:0];
                    cur_minute_next = (req_reg.set_minute > 8'd59) ? 6'd59
                                                                    : req_reg.set_minute[5:0];
                    cur_second_next = (req_reg.set_second > 8'd59) ? 6'd59
                                                                    : req_reg.set_second[5:0];
                end
            end
            OP_DAYS_INIT:
            begin
                days_next = 16'(yo) * 16'd365 + 16'(yo_p3[7:2]) + 16'(cur_day_reg) - 16'd1
                          + DAYS_TO_2000;
                mcnt_next = 4'd1;
            end
            OP_MONTH_SUM:
            begin
                if (mcnt_reg < cur_month_reg)
                begin
                    days_next = days_reg + 16'(sum_dim);
                    mcnt_next = mcnt_reg + 4'd1;
                end
            end
            OP_MUL_DAY:
            begin
                epoch_next = day_prod[31:0];
            end
            OP_ADD_TOD:
            begin
                epoch_next = epoch_reg + 32'(tod);
            end
            OP_WDAY_END:
            begin
                wday_next = div_rem[2:0];
            end
            OP_ADD_OFF:
            begin
                err_next = !off_zero && off_bad;
                if (!off_zero && !off_bad)
                    epoch_next = nt[31:0];
            end
            OP_DAY_END:
            begin
                days_next = div_quo[15:0];
                rem_next  = div_rem;
            end
            OP_HOUR_END:
            begin
                conv_hour_next = div_quo[4:0];
                rem_next       = div_rem;
            end
            OP_MIN_END:
            begin
                conv_min_next = div_quo[5:0];
                conv_sec_next = div_rem[5:0];
            end
            OP_QUAD_END:
            begin
                conv_year_next  = YEAR_MIN + {div_quo[9:0], 2'b00};
                conv_month_next = 4'd1;
                rest_next       = div_rem[10:0];
            end
            OP_YEAR_END:
            begin
                conv_year_next = conv_year_reg + 12'd1 + {10'd0, div_quo[1:0]};
                rest_next      = div_rem[10:0];
            end
            OP_MONTH_CONV:
            begin
                if (!conv_done)
                begin
                    rest_next       = rest_reg - 11'(conv_dim);
                    conv_month_next = conv_month_reg + 4'd1;
                end
            end
            OP_COMMIT:
            begin
                cur_year_next   = conv_year_reg;
                cur_month_next  = conv_month_reg;
                cur_day_next    = 5'(rest_reg + 11'd1);
                cur_hour_next   = conv_hour_reg;
                cur_minute_next = conv_min_reg;
                cur_second_next = conv_sec_reg;
            end
            OP_OUT:
            begin
                out_next.year          = cur_year_reg;
                out_next.month         = cur_month_reg;
                out_next.day           = cur_day_reg;
                out_next.hour          = cur_hour_reg;
                out_next.minute        = cur_minute_reg;
                out_next.second        = cur_second_reg;
                out_next.weekday       = wday_reg;
                out_next.epoch_seconds = epoch_reg;
                out_next.range_error   = err_reg;
                out_valid_next         = 1'b1;
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    // stored date and time and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_year_reg   <= YEAR_MIN;
            cur_month_reg  <= 4'd1;
            cur_day_reg    <= 5'd1;
            cur_hour_reg   <= 5'd0;
            cur_minute_reg <= 6'd0;
            cur_second_reg <= 6'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_year_reg   <= cur_year_next;
            cur_month_reg  <= cur_month_next;
            cur_day_reg    <= cur_day_next;
            cur_hour_reg   <= cur_hour_next;
            cur_minute_reg <= cur_minute_next;
            cur_second_reg <= cur_second_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        days_reg       <= days_next;
        mcnt_reg       <= mcnt_next;
        epoch_reg      <= epoch_next;
        rem_reg        <= rem_next;
        wday_reg       <= wday_next;
        err_reg        <= err_next;
        conv_year_reg  <= conv_year_next;
        conv_month_reg <= conv_month_next;
        rest_reg       <= rest_next;
        conv_hour_reg  <= conv_hour_next;
        conv_min_reg   <= conv_min_next;
        conv_sec_reg   <= conv_sec_next;
        out_reg        <= out_next;
    end

    // status back to the controller
    always_comb
    begin
        status.func         = req_reg.func;
        status.month_done   = mcnt_reg >= cur_month_reg;
        status.off_skip     = off_zero || off_bad;
        status.rest_ge_leap = rest_reg >= DAYS_LEAP_YEAR;
        status.conv_done    = conv_done;
        status.div_busy     = div_busy;
        status.out_free     = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

[design/cdta_ctrl.sv]
// controller: sequences load, day count, divisions and month walks
// depends on cdta_pkg for the command and status types
module cdta_ctrl
    import cdta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_DAYS_INIT,
        S_MONTH_SUM,
        S_MUL_DAY,
        S_ADD_TOD,
        S_WDAY_START,
        S_WDAY_END,
        S_ADD_OFF,
        S_DAY_START,
        S_DAY_END,
        S_HOUR_START,
        S_HOUR_END,
        S_MIN_START,
        S_MIN_END,
        S_QUAD_START,
        S_QUAD_END,
        S_YEAR_CHECK,
        S_YEAR_START,
        S_YEAR_END,
        S_MONTH_CONV,
        S_COMMIT,
        S_OUT,
        S_DIV_WAIT
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   adj_done_reg, adj_done_next;

    // next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        adj_done_next = adj_done_reg;
        cmd.op        = OP_NONE;
        req_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op        = OP_CAPTURE;
                    adj_done_next = 1'b0;
                    state_next    = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = S_DAYS_INIT;
            end
            S_DAYS_INIT:
            begin
                cmd.op     = OP_DAYS_INIT;
                state_next = S_MONTH_SUM;
            end
            S_MONTH_SUM:
            begin
                cmd.op = OP_MONTH_SUM;
                if (status.month_done)
                    state_next = S_MUL_DAY;
            end
            S_MUL_DAY:
            begin
                cmd.op     = OP_MUL_DAY;
                state_next = S_ADD_TOD;
            end
            S_ADD_TOD:
            begin
                cmd.op     = OP_ADD_TOD;
                state_next = S_WDAY_START;
            end
            S_WDAY_START:
            begin
                cmd.op     = OP_WDAY_START;
                ret_next   = S_WDAY_END;
                state_next = S_DIV_WAIT;
            end
            S_WDAY_END:
            begin
                cmd.op = OP_WDAY_END;
                if (status.func && !adj_done_reg)
                    state_next = S_ADD_OFF;
                else
                    state_next = S_OUT;
            end
            S_ADD_OFF:
            begin
                cmd.op        = OP_ADD_OFF;
                adj_done_next = 1'b1;
                if (status.off_skip)
                    state_next = S_OUT;
                else
                    state_next = S_DAY_START;
            end
            S_DAY_START:
            begin
                cmd.op     = OP_DAY_START;
                ret_next   = S_DAY_END;
                state_next = S_DIV_WAIT;
            end
            S_DAY_END:
            begin
                cmd.op     = OP_DAY_END;
                state_next = S_HOUR_START;
            end
            S_HOUR_START:
            begin
                cmd.op     = OP_HOUR_START;
                ret_next   = S_HOUR_END;
                state_next = S_DIV_WAIT;
            end
            S_HOUR_END:
            begin
                cmd.op     = OP_HOUR_END;
                state_next = S_MIN_START;
            end
            S_MIN_START:
            begin
                cmd.op     = OP_MIN_START;
                ret_next   = S_MIN_END;
                state_next = S_DIV_WAIT;
            end
            S_MIN_END:
            begin
                cmd.op     = OP_MIN_END;
                state_next = S_QUAD_START;
            end
            S_QUAD_START:
            begin
                cmd.op     = OP_QUAD_START;
                ret_next   = S_QUAD_END;
                state_next = S_DIV_WAIT;
            end
            S_QUAD_END:
            begin
                cmd.op     = OP_QUAD_END;
                state_next = S_YEAR_CHECK;
            end
            S_YEAR_CHECK:
            begin
                if (status.rest_ge_leap)
                    state_next = S_YEAR_START;
                else
                    state_next = S_MONTH_CONV;
            end
            S_YEAR_START:
            begin
                cmd.op     = OP_YEAR_START;
                ret_next   = S_YEAR_END;
                state_next = S_DIV_WAIT;
            end
            S_YEAR_END:
            begin
                cmd.op     = OP_YEAR_END;
                state_next = S_MONTH_CONV;
            end
            S_MONTH_CONV:
            begin
                cmd.op = OP_MONTH_CONV;
                if (status.conv_done)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // recount the new date for epoch and weekday
                cmd.op     = OP_COMMIT;
                state_next = S_DAYS_INIT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            S_DIV_WAIT:
            begin
                if (!status.div_busy)
                    state_next = ret_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and sequencing flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            adj_done_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            adj_done_reg <= adj_done_next;
        end
    end

endmodule

[design/calendar_date_time_adjust.sv]
// calendar date and time register with clamped load and signed seconds adjust
// each request runs month walks and shared divisions: one division per load or per
// zero or refused adjust, six or seven per other adjust
// throughput: one request in flight; the next is taken once the result is registered
// reset: date and time go to 2000-01-01 00:00:00 at once, no clearing pass
module calendar_date_time_adjust
    import cdta_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cdta_stream_if.sink   req,
    cdta_stream_if.source rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       req_ready;
    logic       rsp_valid;
    rsp_t       rsp_data;

    cdta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cdta_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_data  (req.data),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_data;

`ifndef SYNTHESIS
    // an accepted request closes the input until its result is issued
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request channel still open after accept");

    // a result is only written into a free output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_OUT |-> status.out_free)
        else $error("result written over a pending result");

    // the divider is never restarted in the middle of a division
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WDAY_START || cmd.op == OP_DAY_START || cmd.op == OP_HOUR_START ||
         cmd.op == OP_MIN_START || cmd.op == OP_QUAD_START || cmd.op == OP_YEAR_START)
        |-> !status.div_busy)
        else $error("divider started while busy");
`endif

endmodule

[dv/tb_top.sv]
// self-checking bench for calendar_date_time_adjust: directed table, then random requests
// depends on cdta_pkg (payload types) and cdta_stream_if (valid/ready channel)
`timescale 1ns / 1ps

module tb_top
    import cdta_pkg::*;
();

    localparam longint SEC_DAY        = 86400;
    localparam longint DAYS_1970_2000 = 10957;
    localparam longint INSTANT_FIRST  = 64'd946684800;
    localparam longint INSTANT_LAST   = 64'd4102444799;
    localparam int     DIR_ROWS       = 26;
    localparam int     RAND_ITEMS     = 430;
    localparam int     PHASE_ITEMS    = 108;
    localparam int     DRAIN_CYCLES   = 400;
    localparam int     CYCLE_LIMIT    = 1000000;
    localparam int     REPORT_MAX     = 10;

    // one row of the directed table
    typedef struct {
        req_t req;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    cdta_stream_if #(.T(req_t)) req_ch ();
    cdta_stream_if #(.T(rsp_t)) rsp_ch ();

    calendar_date_time_adjust dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // calendar state tracked by the bench
    bit [11:0] cal_year;
    bit [3:0]  cal_month;
    bit [4:0]  cal_day;
    bit [4:0]  cal_hour;
    bit [5:0]  cal_min;
    bit [5:0]  cal_sec;

    rsp_t      pending_readings [$];
    dir_row_t  dir_tab [DIR_ROWS];
    int        src_idle_pct;
    int        sink_stall_pct;
    int        bad_results;
    int        result_index;
    int        cycle_count;

    // month length, every fourth year leap
    function automatic int unsigned month_length(int unsigned m, int unsigned y);
        if (m < 1)
            m = 1;
        if (m > 12)
            m = 12;
        case (m)
            2:          return (y % 4 == 0) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    // days since 1970-01-01
    function automatic longint day_number(int unsigned y, int unsigned m, int unsigned d);
        int unsigned yo;
        longint      n;
        yo = y - 2000;
        n = longint'(yo) * 365 + longint'((yo + 3) / 4);
        for (int unsigned k = 1; k < m && k <= 12; k++)
            n += month_length(k, y);
        n += longint'(d) - 1;
        return n + DAYS_1970_2000;
    endfunction

    function automatic longint current_instant();
        return day_number(cal_year, cal_month, cal_day) * SEC_DAY +
               longint'(cal_hour) * 3600 + longint'(cal_min) * 60 + longint'(cal_sec);
    endfunction

    // break an instant in range back into calendar fields
    function automatic void set_from_instant(longint t);
        longint      days;
        longint      sod;
        longint      d;
        longint      r;
        int unsigned y;
        int unsigned m;
        days = t / SEC_DAY;
        sod = t % SEC_DAY;
        d = days - DAYS_1970_2000;
        y = 2000 + 4 * 32'(d / 1461);
        r = d % 1461;
        m = 1;
        if (r >= 366)
        begin
            r -= 366;
            y += 1 + 32'(r / 365);
            r = r % 365;
        end
        while (m < 12 && r >= longint'(month_length(m, y)))
        begin
            r -= longint'(month_length(m, y));
            m++;
        end
        cal_year  = 12'(y);
        cal_month = 4'(m);
        cal_day   = 5'(r + 1);
        cal_hour  = 5'(sod / 3600);
        cal_min   = 6'((sod % 3600) / 60);
        cal_sec   = 6'(sod % 60);
    endfunction

    // advance the calendar by one request and return the reading it produces
    function automatic rsp_t cal_step(req_t r);
        rsp_t        res;
        longint      off;
        longint      nt;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned h;
        int unsigned mi;
        int unsigned s;
        bit          refused;
        refused = 1'b0;
        if (r.func == 1'b0)
        begin
            y = r.set_year;
            m = r.set_month;
            d = r.set_day;
            h = r.set_hour;
            mi = r.set_minute;
            s = r.set_second;
            if (y < 2000)
                y = 2000;
            if (y > 2099)
                y = 2099;
            if (m < 1)
                m = 1;
            if (m > 12)
                m = 12;
            if (d < 1)
                d = 1;
            if (d > month_length(m, y))
                d = month_length(m, y);
            if (h > 23)
                h = 23;
            if (mi > 59)
                mi = 59;
            if (s > 59)
                s = 59;
            cal_year  = 12'(y);
            cal_month = 4'(m);
            cal_day   = 5'(d);
            cal_hour  = 5'(h);
            cal_min   = 6'(mi);
            cal_sec   = 6'(s);
        end
        else
        begin
            off = r.offset_seconds;
            if (off != 0)
            begin
                nt = current_instant() + off;
                if (nt < INSTANT_FIRST || nt > INSTANT_LAST)
                    refused = 1'b1;
                else
                    set_from_instant(nt);
            end
        end
        res.year          = cal_year;
        res.month         = cal_month;
        res.day           = cal_day;
        res.hour          = cal_hour;
        res.minute        = cal_min;
        res.second        = cal_sec;
        res.weekday       = 3'((day_number(cal_year, cal_month, cal_day) + 4) % 7);
        res.epoch_seconds = 32'(current_instant());
        res.range_error   = refused;
        return res;
    endfunction

    function automatic req_t load_req(int y, int m, int d, int h, int mi, int s);
        req_t r;
        r = '0;
        r.func       = 1'b0;
        r.set_year   = 12'(y);
        r.set_month  = 8'(m);
        r.set_day    = 8'(d);
        r.set_hour   = 8'(h);
        r.set_minute = 8'(mi);
        r.set_second = 8'(s);
        return r;
    endfunction

    function automatic req_t adjust_req(logic signed [31:0] off);
        req_t r;
        r = '0;
        r.func           = 1'b1;
        r.offset_seconds = off;
        return r;
    endfunction

    function automatic rsp_t reading(int y, int m, int d, int h, int mi, int s, int wd,
                                     longint ep, bit err);
        rsp_t r;
        r.year          = 12'(y);
        r.month         = 4'(m);
        r.day           = 5'(d);
        r.hour          = 5'(h);
        r.minute        = 6'(mi);
        r.second        = 6'(s);
        r.weekday       = 3'(wd);
        r.epoch_seconds = 32'(ep);
        r.range_error   = err;
        return r;
    endfunction

    function automatic dir_row_t row(req_t r, bit typed, rsp_t want);
        dir_row_t x;
        x.req   = r;
        x.typed = typed;
        x.want  = want;
        return x;
    endfunction

    // random request, mostly adjusts of varied reach, otherwise loads of mostly sensible dates
    function automatic req_t random_req();
        req_t        r;
        longint      now;
        longint      off;
        longint      target;
        int unsigned pick;
        bit          use_off;
        r.func           = 1'b1;
        r.set_year       = 12'($urandom);
        r.set_month      = 8'($urandom);
        r.set_day        = 8'($urandom);
        r.set_hour       = 8'($urandom);
        r.set_minute     = 8'($urandom);
        r.set_second     = 8'($urandom);
        r.offset_seconds = $urandom;
        now = current_instant();
        use_off = 1'b0;
        off = 0;
        if ($urandom_range(99) < 30)
        begin
            r.func = 1'b0;
            pick = $urandom_range(99);
            if (pick < 70)
                r.set_year = 12'(2000 + $urandom_range(99));
            else if (pick < 85)
            begin
                case ($urandom_range(5))
                    0:       r.set_year = 12'd2000;
                    1:       r.set_year = 12'd2099;
                    2:       r.set_year = 12'd1999;
                    3:       r.set_year = 12'd2100;
                    4:       r.set_year = 12'd0;
                    default: r.set_year = 12'hfff;
                endcase
            end
            if ($urandom_range(99) < 80)
                r.set_month = 8'(1 + $urandom_range(11));
            pick = $urandom_range(99);
            if (pick < 40)
                r.set_day = 8'(28 + $urandom_range(3));
            else if (pick < 80)
                r.set_day = 8'(1 + $urandom_range(30));
            if ($urandom_range(99) < 80)
                r.set_hour = 8'(($urandom_range(1) == 0) ? 23 : $urandom_range(23));
            if ($urandom_range(99) < 80)
                r.set_minute = 8'(($urandom_range(1) == 0) ? 59 : $urandom_range(59));
            if ($urandom_range(99) < 80)
                r.set_second = 8'(($urandom_range(1) == 0) ? 59 : $urandom_range(59));
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                r.offset_seconds = '0;
            else if (pick < 25)
            begin
                off = longint'($urandom_range(240)) - 120;
                use_off = 1'b1;
            end
            else if (pick < 35)
            begin
                // land just around the next midnight
                off = SEC_DAY - (now % SEC_DAY) + longint'($urandom_range(2)) - 1;
                use_off = 1'b1;
            end
            else if (pick < 55)
            begin
                off = longint'($urandom_range(400000)) - 200000;
                use_off = 1'b1;
            end
            else if (pick < 72)
            begin
                off = longint'($urandom_range(80000000)) - 40000000;
                use_off = 1'b1;
            end
            else if (pick < 85)
            begin
                // aim at the first or last second of the range
                target = ($urandom_range(1) == 0) ? INSTANT_FIRST : INSTANT_LAST;
                off = target - now + longint'($urandom_range(4)) - 2;
                use_off = (off >= -64'sd2147483648) && (off <= 64'sd2147483647);
            end
            if (use_off)
                r.offset_seconds = 32'(off);
        end
        return r;
    endfunction

    // present one request and book its expected reading on acceptance
    task automatic send_req(input req_t r, input bit typed, input rsp_t want);
        rsp_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = cal_step(r);
        pending_readings.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** calendar_date_time_adjust: FAILED **");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin : result_sink
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // compare each accepted reading with the oldest booked one
    always @(posedge clk)
    begin : reading_check
        rsp_t want;
        rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (pending_readings.size() == 0)
            begin
                bad_results = bad_results + 1;
                if (bad_results <= REPORT_MAX)
                    $display("result %0d: unexpected reading %0d-%0d-%0d %0d:%0d:%0d",
                             result_index, got.year, got.month, got.day,
                             got.hour, got.minute, got.second);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got.year !== want.year || got.month !== want.month ||
                    got.day !== want.day || got.hour !== want.hour ||
                    got.minute !== want.minute || got.second !== want.second ||
                    got.weekday !== want.weekday ||
                    got.epoch_seconds !== want.epoch_seconds ||
                    got.range_error !== want.range_error)
                begin
                    bad_results = bad_results + 1;
                    if (bad_results <= REPORT_MAX)
                    begin
                        $display("result %0d: expected %0d-%0d-%0d %0d:%0d:%0d wd %0d epoch %0d err %0d",
                                 result_index, want.year, want.month, want.day, want.hour,
                                 want.minute, want.second, want.weekday,
                                 want.epoch_seconds, want.range_error);
                        $display("result %0d:      got %0d-%0d-%0d %0d:%0d:%0d wd %0d epoch %0d err %0d",
                                 result_index, got.year, got.month, got.day, got.hour,
                                 got.minute, got.second, got.weekday,
                                 got.epoch_seconds, got.range_error);
                    end
                end
            end
            result_index = result_index + 1;
        end
    end

    // stimulus: reset, directed table, random phases, drain
    initial
    begin : stimulus
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        bad_results    = 0;
        result_index   = 0;
        cal_year       = 12'd2000;
        cal_month      = 4'd1;
        cal_day        = 5'd1;
        cal_hour       = 5'd0;
        cal_min        = 6'd0;
        cal_sec        = 6'd0;

        dir_tab = '{
            // reset value, then refusal below the range
            row(adjust_req(32'sd0), 1'b1, reading(2000, 1, 1, 0, 0, 0, 6, 64'd946684800, 1'b0)),
            row(adjust_req(-32'sd1), 1'b1, reading(2000, 1, 1, 0, 0, 0, 6, 64'd946684800, 1'b1)),
            // largest forward step, then largest backward step lands one second short
            row(adjust_req(32'sh7fffffff), 1'b0, '0),
            row(adjust_req(32'sh80000000), 1'b0, '0),
            // all-zero and all-ones loads clamp to the range ends
            row(load_req(0, 0, 0, 0, 0, 0), 1'b1,
                reading(2000, 1, 1, 0, 0, 0, 6, 64'd946684800, 1'b0)),
            row(load_req(4095, 255, 255, 255, 255, 255), 1'b1,
                reading(2099, 12, 31, 23, 59, 59, 4, 64'd4102444799, 1'b0)),
            row(adjust_req(32'sd1), 1'b1,
                reading(2099, 12, 31, 23, 59, 59, 4, 64'd4102444799, 1'b1)),
            row(adjust_req(32'sh80000000), 1'b0, '0),
            // day clamp in leap and common february
            row(load_req(2000, 2, 30, 12, 30, 30), 1'b0, '0),
            row(load_req(2001, 2, 31, 0, 0, 0), 1'b0, '0),
            // year saturation and one-past field limits
            row(load_req(2100, 13, 31, 24, 60, 60), 1'b0, '0),
            row(load_req(1999, 0, 0, 0, 0, 0), 1'b0, '0),
            // month rollover
            row(load_req(2000, 1, 31, 23, 59, 59), 1'b0, '0),
            row(adjust_req(32'sd1), 1'b0, '0),
            // leap day and the step past it
            row(load_req(2000, 2, 28, 23, 59, 59), 1'b0, '0),
            row(adjust_req(32'sd1), 1'b0, '0),
            row(adjust_req(32'sd86400), 1'b0, '0),
            // year rollover and back
            row(load_req(2004, 12, 31, 23, 59, 59), 1'b0, '0),
            row(adjust_req(32'sd1), 1'b0, '0),
            row(adjust_req(-32'sd1), 1'b0, '0),
            // exact first second, then refusal
            row(load_req(2000, 1, 1, 0, 0, 1), 1'b0, '0),
            row(adjust_req(-32'sd1), 1'b0, '0),
            row(adjust_req(-32'sd1), 1'b0, '0),
            // exact last second
            row(load_req(2099, 12, 31, 23, 59, 58), 1'b0, '0),
            row(adjust_req(32'sd1), 1'b0, '0),
            // zero adjust away from reset
            row(load_req(2050, 6, 15, 8, 0, 0), 1'b0, '0)
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
        send_req(adjust_req(32'sd0), 1'b0, '0);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            case (i / PHASE_ITEMS)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 85;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 85;
                end
                default:
                begin
                    src_idle_pct   = 18;
                    sink_stall_pct = 18;
                end
            endcase
            send_req(random_req(), 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        // wait for outstanding readings, then watch for strays
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (bad_results == 0)
            $display("** calendar_date_time_adjust: PASSED **");
        else
            $display("** calendar_date_time_adjust: FAILED **");
        $finish;
    end

endmodule

[files.f]
design/cdta_pkg.sv
design/cdta_stream_if.sv
design/cdta_div.sv
design/cdta_datapath.sv
design/cdta_ctrl.sv
design/calendar_date_time_adjust.sv
dv/tb_top.sv
